@@ hdl/ccrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ccrc_pkg: shared types and helpers for the configurable CRC engine
// Register indexes, the derived-configuration bundle and bit reversal.
// ----------------------------------------------------------------------------
package ccrc_pkg;

  localparam int unsigned CrcW   = 32;  // remainder / result width
  localparam int unsigned DataW  = 8;   // message byte
  localparam int unsigned WidthW = 6;   // crc_width register
  localparam int unsigned IdxW   = 3;   // config register index
  localparam int unsigned AlignW = 3;   // up to 7 bits of alignment
  localparam int unsigned ShiftW = 5;   // up to 31 bits of shift

  localparam logic [CrcW-1:0]   TopOfByte    = 32'h0000_0080;
  localparam logic [WidthW-1:0] WidthReset   = 6'd8;
  localparam logic [CrcW-1:0]   PolyReset    = 32'h0000_0031;
  localparam logic [WidthW-1:0] WidthMax     = 6'd32;

  typedef enum logic [IdxW-1:0] {
    RegCrcWidth   = 3'd0,
    RegPolynomial = 3'd1,
    RegInitValue  = 3'd2,
    RegXorOut     = 3'd3,
    RegReflectIn  = 3'd4,
    RegReflectOut = 3'd5
  } ccrc_reg_e;

  // Settings decoded once from the raw registers
  typedef struct packed {
    logic [CrcW-1:0]   mask;        // low width bits
    logic [CrcW-1:0]   amask;       // mask lifted to the byte top for narrow CRCs
    logic [CrcW-1:0]   poly_a;      // polynomial, masked and aligned
    logic [CrcW-1:0]   topm;        // one-hot feedback tap
    logic [CrcW-1:0]   init_m;      // masked init value
    logic [CrcW-1:0]   xor_out;
    logic [AlignW-1:0] align;
    logic [ShiftW-1:0] lift;        // data byte position
    logic [ShiftW-1:0] rev_shift;   // 32 - width
    logic              reflect_in;
    logic              reflect_out;
  } ccrc_cfg_t;

  function automatic logic [DataW-1:0] rev8(input logic [DataW-1:0] v);
    logic [DataW-1:0] r;
    for (int k = 0; k < DataW; k++) begin
      r[k] = v[DataW-1-k];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] rev32(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int k = 0; k < CrcW; k++) begin
      r[k] = v[CrcW-1-k];
    end
    return r;
  endfunction

endpackage

@@ hdl/ccrc_cfg.sv @@
// ----------------------------------------------------------------------------
// ccrc_cfg: configuration registers
// Holds the six settings and decodes them into masks, taps and shifts.
// ----------------------------------------------------------------------------
module ccrc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [ccrc_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [ccrc_pkg::CrcW-1:0]    cfg_data_i,
  output ccrc_pkg::ccrc_cfg_t          cfg_o
);
  import ccrc_pkg::*;

  logic [WidthW-1:0] crc_width_q;
  logic [CrcW-1:0]   polynomial_q;
  logic [CrcW-1:0]   init_value_q;
  logic [CrcW-1:0]   xor_out_q;
  logic              reflect_in_q;
  logic              reflect_out_q;

  logic [WidthW-1:0] w_eff;
  logic              narrow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_width_q   <= WidthReset;
      polynomial_q  <= PolyReset;
      init_value_q  <= '0;
      xor_out_q     <= '0;
      reflect_in_q  <= 1'b0;
      reflect_out_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCrcWidth:   crc_width_q   <= cfg_data_i[WidthW-1:0];
        RegPolynomial: polynomial_q  <= cfg_data_i;
        RegInitValue:  init_value_q  <= cfg_data_i;
        RegXorOut:     xor_out_q     <= cfg_data_i;
        RegReflectIn:  reflect_in_q  <= cfg_data_i[0];
        RegReflectOut: reflect_out_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Width clamped to 1..32
  always_comb begin
    if (crc_width_q == '0) begin
      w_eff = 6'd1;
    end else if (crc_width_q > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = crc_width_q;
    end
  end

  assign narrow = (w_eff < 6'(DataW));

  always_comb begin
    cfg_o = '0;
    if (w_eff == WidthMax) begin
      cfg_o.mask = '1;
    end else begin
      cfg_o.mask = (32'd1 << w_eff[ShiftW-1:0]) - 32'd1;
    end
    cfg_o.align     = narrow ? AlignW'(6'(DataW) - w_eff) : '0;
    cfg_o.lift      = narrow ? '0 : ShiftW'(w_eff - 6'(DataW));
    cfg_o.topm      = narrow ? TopOfByte : (32'd1 << ShiftW'(w_eff - 6'd1));
    cfg_o.amask     = cfg_o.mask << cfg_o.align;
    cfg_o.poly_a    = (polynomial_q & cfg_o.mask) << cfg_o.align;
    cfg_o.init_m    = init_value_q & cfg_o.mask;
    cfg_o.xor_out   = xor_out_q;
    cfg_o.rev_shift = ShiftW'(WidthMax - w_eff);
    cfg_o.reflect_in  = reflect_in_q;
    cfg_o.reflect_out = reflect_out_q;
  end

endmodule

@@ hdl/ccrc_fold.sv @@
// ----------------------------------------------------------------------------
// ccrc_fold: byte fold and finish
// Eight unrolled shift/XOR steps, then reflection, final XOR and mask.
// ----------------------------------------------------------------------------
module ccrc_fold (
  input  ccrc_pkg::ccrc_cfg_t          cfg_i,
  input  logic [ccrc_pkg::CrcW-1:0]    rem_i,
  input  logic [ccrc_pkg::DataW-1:0]   data_i,
  input  logic                         first_i,
  output logic [ccrc_pkg::CrcW-1:0]    rem_o,
  output logic [ccrc_pkg::CrcW-1:0]    crc_o
);
  import ccrc_pkg::*;

  logic [CrcW-1:0]  rem_start;
  logic [DataW-1:0] data_r;
  logic [CrcW-1:0]  acc;
  logic [CrcW-1:0]  res_raw;

  always_comb begin
    rem_start = first_i ? cfg_i.init_m : (rem_i & cfg_i.mask);
    data_r    = cfg_i.reflect_in ? rev8(data_i) : data_i;
    acc       = (rem_start << cfg_i.align) ^ (CrcW'(data_r) << cfg_i.lift);
    for (int k = 0; k < DataW; k++) begin
      if (|(acc & cfg_i.topm)) begin
        acc = ((acc << 1) ^ cfg_i.poly_a) & cfg_i.amask;
      end else begin
        acc = (acc << 1) & cfg_i.amask;
      end
    end
    rem_o   = (acc >> cfg_i.align) & cfg_i.mask;
    res_raw = cfg_i.reflect_out ? (rev32(rem_o) >> cfg_i.rev_shift) : rem_o;
    crc_o   = (res_raw ^ cfg_i.xor_out) & cfg_i.mask;
  end

endmodule

@@ hdl/configurable_crc_engine.sv @@
// ----------------------------------------------------------------------------
// configurable_crc_engine: byte-serial CRC with run-time parameters
// Result: crc_result is registered; a byte with last_byte set waits in the
// input register for a free result slot, then loads the result register.
// Throughput: one byte per cycle unless a closing byte waits for the slot; the
// fold is combinational between the input and remainder/result registers.
// Reset: remainder clears to zero, settings return to width 8, poly 0x31.
// ----------------------------------------------------------------------------
module configurable_crc_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ccrc_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [ccrc_pkg::CrcW-1:0]    cfg_data_i,
  // byte input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ccrc_pkg::DataW-1:0]   data_byte_i,
  input  logic                         first_byte_i,
  input  logic                         last_byte_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccrc_pkg::CrcW-1:0]    crc_result_o
);
  import ccrc_pkg::*;

  ccrc_cfg_t cfg;

  // Stage 1: registered input transaction
  logic             s1_valid_q, s1_valid_d;
  logic [DataW-1:0] s1_data_q;
  logic             s1_first_q;
  logic             s1_last_q;

  // Running remainder and result register
  logic [CrcW-1:0]  rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic [CrcW-1:0]  crc_q, crc_d;

  logic [CrcW-1:0]  fold_rem;
  logic [CrcW-1:0]  fold_crc;
  logic             out_free;
  logic             s1_fire;
  logic             in_fire;

  // Settings must be written only while idle; the block itself does not enforce this, so the port never stalls.
  assign cfg_ready_o = 1'b1;

  ccrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ccrc_fold u_fold (
    .cfg_i   (cfg),
    .rem_i   (rem_q),
    .data_i  (s1_data_q),
    .first_i (s1_first_q),
    .rem_o   (fold_rem),
    .crc_o   (fold_crc)
  );

  // Result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  // A byte that closes a message waits only for the result slot;
  // any other byte retires immediately.
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    rem_d       = s1_fire ? fold_rem : rem_q;
    out_valid_d = out_valid_q;
    crc_d       = crc_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
      crc_d       = fold_crc;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
    end
    crc_q <= crc_d;
  end

  assign out_valid_o  = out_valid_q;
  assign crc_result_o = crc_q;

  // An empty input stage must always take a new transaction.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  // A new result only follows a retired message-closing byte.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a closing byte");

  // A closing byte held by a blocked result slot stays in stage 1.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("closing byte dropped while result pending");

endmodule
